// ----- rtl/core/four_function_calculator_engine_core_assert.svh -----
// Assertion macros for the calculator engine core.
// Expects signals clk and arst_n in the scope of each use.
`ifndef FOUR_FUNCTION_CALCULATOR_ENGINE_CORE_ASSERT_SVH
`define FOUR_FUNCTION_CALCULATOR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define FFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ffc_pkg.sv -----
// Shared types, codes and constants of the calculator engine core.
// No dependencies; compile first.
package ffc_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [3:0] {
		KEY_DIGIT       = 4'd0,
		KEY_ADD         = 4'd1,
		KEY_SUB         = 4'd2,
		KEY_MUL         = 4'd3,
		KEY_DIV         = 4'd4,
		KEY_EQUALS      = 4'd5,
		KEY_CLEAR_ALL   = 4'd6,
		KEY_CLEAR_ENTRY = 4'd7,
		KEY_NEGATE      = 4'd8,
		KEY_PERCENT     = 4'd9
	} key_kind_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

	localparam word_t      LIMIT_POS   = 32'sd214748364;
	localparam word_t      LIMIT_NEG   = -32'sd214748364;
	localparam word_t      PCT_DIVISOR = 32'sd100;
	localparam logic [3:0] DIGIT_MAX   = 4'd9;

	function automatic op_t kind_to_op(input logic [3:0] kind);
		op_t op;
		case (kind)
			KEY_ADD: op = OP_ADD;
			KEY_SUB: op = OP_SUB;
			KEY_MUL: op = OP_MUL;
			KEY_DIV: op = OP_DIV;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

// ----- rtl/core/ffc_if.sv -----
// Valid/ready channel interfaces: key input and display result.
// Depends on ffc_pkg.
interface ffc_key_if import ffc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [3:0] kind;
	logic [3:0] digit;

	modport source(output valid, output kind, output digit, input ready);
	modport sink(input valid, input kind, input digit, output ready);
endinterface

interface ffc_res_if import ffc_pkg::*; ();
	logic       valid;
	logic       ready;
	word_t      shown_value;
	logic       error_flag;
	logic [2:0] pending_op;

	modport source(output valid, output shown_value, output error_flag, output pending_op,
		input ready);
	modport sink(input valid, input shown_value, input error_flag, input pending_op,
		output ready);
endinterface

// ----- rtl/core/four_function_calculator_engine_core.sv -----
// Channel | dir | transfer moves
// key     | in  | kind, digit: one calculator key
// res     | out | shown_value, error_flag, pending_op after that key
//
// Multiply, divide and percent run the shared shift/add unit: it starts on the key transfer,
// runs its 32 bit steps and signals done, and the result is then registered.
// Reset clears accumulator, display, pending op, entry and error flags.
// A key is taken only when the result slot is empty or drains in the same cycle;
// a stalled result holds the next key off, and the unit holds while busy.
`include "four_function_calculator_engine_core_assert.svh"

module four_function_calculator_engine_core import ffc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ffc_key_if.sink   key,
	ffc_res_if.source res
);

	state_t     state_q;
	state_t     state_d;

	word_t      accum_q;
	word_t      disp_q;
	op_t        op_q;
	logic       ent_q;
	logic       err_q;
	logic       res_v_q;

	logic [3:0] pend_kind_q;
	op_t        pend_op_q;

	word_t      n_accum;
	word_t      n_disp;
	op_t        n_op;
	logic       n_ent;
	logic       n_err;
	logic       need_unit;
	logic       do_run;
	op_t        key_op;
	word_t      run_sum;
	word_t      mul10;
	word_t      digit_w;

	alu_req_t   alu_req;
	alu_rsp_t   alu_rsp;
	alu_op_t    unit_op;
	word_t      unit_a;
	word_t      unit_b;
	word_t      unit_res;

	logic       key_xfer;
	logic       finish;

	ffc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (unit_a),
		.b      (unit_b),
		.rsp    (alu_rsp),
		.result (unit_res)
	);

	assign key_op  = kind_to_op(key.kind);
	assign run_sum = (op_q == OP_SUB) ? (accum_q - disp_q) : (accum_q + disp_q);
	assign mul10   = (disp_q <<< 3) + (disp_q <<< 1);
	assign digit_w = word_t'({{(DATA_W-4){1'b0}}, key.digit});

	always_comb begin
		n_accum   = accum_q;
		n_disp    = disp_q;
		n_op      = op_q;
		n_ent     = ent_q;
		n_err     = err_q;
		need_unit = 1'b0;
		do_run    = 1'b0;
		unit_op   = ALU_MUL;
		unit_a    = accum_q;
		unit_b    = disp_q;
		unique case (key.kind) inside
			KEY_DIGIT: begin
				if (key.digit <= DIGIT_MAX) begin
					if (err_q) begin
						n_accum = '0;
						n_op    = OP_NONE;
						n_err   = 1'b0;
						n_disp  = digit_w;
						n_ent   = 1'b1;
					end else if (!ent_q) begin
						n_disp = digit_w;
						n_ent  = 1'b1;
					end else if (!disp_q[DATA_W-1]) begin
						if (disp_q < LIMIT_POS) begin
							n_disp = mul10 + digit_w;
						end
					end else if (disp_q > LIMIT_NEG) begin
						n_disp = mul10 - digit_w;
					end
				end
			end
			KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
				if (!err_q) begin
					if (op_q == OP_NONE) begin
						n_accum = disp_q;
						n_op    = key_op;
						n_ent   = 1'b0;
					end else if (!ent_q) begin
						n_op  = key_op;
						n_ent = 1'b0;
					end else begin
						do_run = 1'b1;
					end
				end
			end
			KEY_EQUALS: begin
				if (!err_q && (op_q != OP_NONE)) begin
					do_run = 1'b1;
				end
			end
			KEY_CLEAR_ALL: begin
				n_accum = '0;
				n_disp  = '0;
				n_op    = OP_NONE;
				n_ent   = 1'b0;
				n_err   = 1'b0;
			end
			KEY_CLEAR_ENTRY: begin
				n_disp = '0;
				n_ent  = 1'b0;
				n_err  = 1'b0;
			end
			KEY_NEGATE: begin
				if (!err_q) begin
					n_disp = -disp_q;
					n_ent  = 1'b1;
				end
			end
			KEY_PERCENT: begin
				if (!err_q) begin
					need_unit = 1'b1;
					unit_op   = ALU_DIV;
					unit_a    = disp_q;
					unit_b    = PCT_DIVISOR;
				end
			end
			default: begin
			end
		endcase
		if (do_run) begin
			case (op_q) inside
				OP_ADD, OP_SUB: begin
					n_accum = run_sum;
					n_disp  = run_sum;
					n_op    = key_op;
					n_ent   = 1'b0;
				end
				OP_MUL: begin
					need_unit = 1'b1;
				end
				OP_DIV: begin
					if (disp_q == '0) begin
						n_err = 1'b1;
					end else begin
						need_unit = 1'b1;
						unit_op   = ALU_DIV;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (key_xfer && need_unit) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (alu_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		key.ready     = (state_q == ST_IDLE) && (!res_v_q || res.ready);
		key_xfer      = key.valid && key.ready;
		finish        = (state_q == ST_BUSY) && alu_rsp.done;
		alu_req.start = key_xfer && need_unit;
		alu_req.op    = unit_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			accum_q <= '0;
			disp_q  <= '0;
			op_q    <= OP_NONE;
			ent_q   <= 1'b0;
			err_q   <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (key_xfer && !need_unit) begin
				accum_q <= n_accum;
				disp_q  <= n_disp;
				op_q    <= n_op;
				ent_q   <= n_ent;
				err_q   <= n_err;
			end else if (finish) begin
				disp_q <= unit_res;
				if (pend_kind_q == KEY_PERCENT) begin
					ent_q <= 1'b1;
				end else begin
					accum_q <= unit_res;
					op_q    <= pend_op_q;
					ent_q   <= 1'b0;
				end
			end
			if ((key_xfer && !need_unit) || finish) begin
				res_v_q <= 1'b1;
			end else if (res.ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_xfer) begin
			pend_kind_q <= key.kind;
			pend_op_q   <= key_op;
		end
	end

	assign res.valid       = res_v_q;
	assign res.shown_value = disp_q;
	assign res.error_flag  = err_q;
	assign res.pending_op  = op_q;

	`FFC_ASSERT_IMP(a_done_in_busy, alu_rsp.done, state_q == ST_BUSY, "unit done outside busy")
	`FFC_ASSERT_IMP(a_busy_no_result, state_q == ST_BUSY, !res_v_q, "result valid while busy")
	`FFC_ASSERT_IMP(a_busy_unit_runs, state_q == ST_BUSY, alu_rsp.busy || alu_rsp.done,
		"busy state without unit activity")
	`FFC_ASSERT_NEXT(a_key_yields, key_xfer, res_v_q || (state_q == ST_BUSY),
		"transfer produced neither result nor run")

endmodule

// ----- rtl/core/ffc_alu.sv -----
// Shared iterative unit: shift-add multiply and restoring signed divide, one bit a cycle.
// Depends on ffc_pkg and the assertion macro header.
`include "four_function_calculator_engine_core_assert.svh"

module ffc_alu import ffc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	input  word_t    a,
	input  word_t    b,
	output alu_rsp_t rsp,
	output word_t    result
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	alu_op_t           op_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] y_q;
	logic              neg_q;

	logic [DATA_W-1:0] a_mag;
	logic [DATA_W-1:0] b_mag;
	logic [DATA_W+1:0] add_a;
	logic [DATA_W+1:0] add_b;
	logic [DATA_W+1:0] sum;
	logic              cin;
	logic              ge;

	assign a_mag = a[DATA_W-1] ? (~a + 1'b1) : a;
	assign b_mag = b[DATA_W-1] ? (~b + 1'b1) : b;

	always_comb begin
		if (op_q == ALU_MUL) begin
			add_a = {2'b00, acc_q};
			add_b = y_q[0] ? {2'b00, x_q} : '0;
			cin   = 1'b0;
		end else begin
			add_a = {1'b0, acc_q, x_q[DATA_W-1]};
			add_b = {1'b0, ~{1'b0, y_q}};
			cin   = 1'b1;
		end
	end

	assign sum = add_a + add_b + {{(DATA_W+1){1'b0}}, cin};
	assign ge  = sum[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			x_q   <= (req.op == ALU_DIV) ? a_mag : a;
			y_q   <= (req.op == ALU_DIV) ? b_mag : b;
			neg_q <= a[DATA_W-1] ^ b[DATA_W-1];
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				acc_q <= sum[DATA_W-1:0];
				x_q   <= {x_q[DATA_W-2:0], 1'b0};
				y_q   <= {1'b0, y_q[DATA_W-1:1]};
			end else begin
				acc_q <= ge ? sum[DATA_W-1:0] : {acc_q[DATA_W-2:0], x_q[DATA_W-1]};
				x_q   <= {x_q[DATA_W-2:0], ge};
			end
		end
	end

	assign result   = (op_q == ALU_MUL) ? acc_q : (neg_q ? (~x_q + 1'b1) : x_q);
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;

	`FFC_ASSERT_IMP(a_start_idle, req.start, !busy_q, "start while unit busy")
	`FFC_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q), "done without a run")
	`FFC_ASSERT_NEXT(a_last_step_done, busy_q && (cnt_q == '0) && !req.start, done_q,
		"last step did not signal done")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for four_function_calculator_engine_core: random and directed key sequences.
// Keys are checked against a behavioral calculator model kept in this file.
// Depends on ffc_pkg, ffc_if.sv and the core RTL.
module testbench;
	import ffc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		word_t shown;
		logic  err;
		op_t   op;
	} display_t;

	logic clk = 1'b0;
	logic arst_n;

	ffc_key_if key_ch ();
	ffc_res_if res_ch ();

	four_function_calculator_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.key(key_ch),
		.res(res_ch)
	);

	always #4 clk = ~clk;

	word_t calc_accum;
	word_t calc_display;
	op_t   calc_op;
	logic  calc_entering;
	logic  calc_err;

	display_t shown_q[$];

	int fail_count = 0;
	int cycle_count = 0;
	int keys_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_gen = 0;
	int hold_seen = 0;
	int hold_left = 0;

	function automatic void calc_clear();
		calc_accum = '0;
		calc_display = '0;
		calc_op = OP_NONE;
		calc_entering = 1'b0;
		calc_err = 1'b0;
	endfunction

	function automatic void calc_apply(word_t rhs);
		case (calc_op)
			OP_ADD: calc_accum = calc_accum + rhs;
			OP_SUB: calc_accum = calc_accum - rhs;
			OP_MUL: calc_accum = calc_accum * rhs;
			OP_DIV: begin
				if (rhs == 0)
					calc_err = 1'b1;
				else if (rhs == -1)
					calc_accum = -calc_accum;
				else
					calc_accum = calc_accum / rhs;
			end
			default: ;
		endcase
	endfunction

	function automatic void calc_operator(op_t op);
		if (calc_err)
			return;
		if (calc_op == OP_NONE) begin
			calc_accum = calc_display;
		end else if (calc_entering) begin
			calc_apply(calc_display);
			if (calc_err)
				return;
			calc_display = calc_accum;
		end
		calc_op = op;
		calc_entering = 1'b0;
	endfunction

	function automatic void predict_key(logic [3:0] kind, logic [3:0] digit);
		word_t dv;
		dv = {28'd0, digit};
		case (kind)
			KEY_DIGIT: begin
				if (digit <= DIGIT_MAX) begin
					if (calc_err)
						calc_clear();
					if (!calc_entering) begin
						calc_display = dv;
						calc_entering = 1'b1;
					end else if (calc_display >= 0) begin
						if (calc_display < LIMIT_POS)
							calc_display = calc_display * 10 + dv;
					end else begin
						if (calc_display > LIMIT_NEG)
							calc_display = calc_display * 10 - dv;
					end
				end
			end
			KEY_ADD: calc_operator(OP_ADD);
			KEY_SUB: calc_operator(OP_SUB);
			KEY_MUL: calc_operator(OP_MUL);
			KEY_DIV: calc_operator(OP_DIV);
			KEY_EQUALS: begin
				if (!calc_err && calc_op != OP_NONE) begin
					calc_apply(calc_display);
					if (!calc_err) begin
						calc_display = calc_accum;
						calc_op = OP_NONE;
						calc_entering = 1'b0;
					end
				end
			end
			KEY_CLEAR_ALL: calc_clear();
			KEY_CLEAR_ENTRY: begin
				calc_display = '0;
				calc_entering = 1'b0;
				calc_err = 1'b0;
			end
			KEY_NEGATE: begin
				if (!calc_err) begin
					calc_display = -calc_display;
					calc_entering = 1'b1;
				end
			end
			KEY_PERCENT: begin
				if (!calc_err) begin
					calc_display = calc_display / PCT_DIVISOR;
					calc_entering = 1'b1;
				end
			end
			default: ;
		endcase
		shown_q.push_back('{calc_display, calc_err, calc_op});
	endfunction

	task automatic send_key(input logic [3:0] kind, input logic [3:0] digit);
		if ($urandom_range(99) < send_idle_pct) begin
			key_ch.valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		key_ch.valid = 1'b1;
		key_ch.kind = kind;
		key_ch.digit = digit;
		do @(posedge clk); while (!key_ch.ready);
		predict_key(kind, digit);
		keys_sent++;
		@(negedge clk);
	endtask

	task automatic send_number();
		int len;
		len = ($urandom_range(3) == 0) ? $urandom_range(10, 5) : $urandom_range(3, 1);
		repeat (len) send_key(KEY_DIGIT, 4'($urandom_range(9)));
	endtask

	task automatic test_entry_limit();
		logic [3:0] digits [9] = '{4'd2, 4'd1, 4'd4, 4'd7, 4'd4, 4'd8, 4'd3, 4'd6, 4'd4};
		send_key(KEY_CLEAR_ALL, 4'd0);
		foreach (digits[i])
			send_key(KEY_DIGIT, digits[i]);
		send_key(KEY_DIGIT, 4'd7);
		send_key(KEY_NEGATE, 4'd15);
		send_key(KEY_DIGIT, 4'd9);
	endtask

	task automatic test_overflow_division();
		send_key(KEY_MUL, 4'd0);
		send_key(KEY_DIGIT, 4'd12);
		send_key(KEY_DIGIT, 4'd1);
		send_key(KEY_DIGIT, 4'd0);
		send_key(KEY_SUB, 4'd0);
		send_key(KEY_DIGIT, 4'd8);
		send_key(KEY_DIV, 4'd0);
		send_key(KEY_DIGIT, 4'd1);
		send_key(KEY_NEGATE, 4'd0);
		send_key(KEY_EQUALS, 4'd0);
	endtask

	task automatic test_error_recovery();
		send_key(KEY_DIV, 4'd0);
		send_key(KEY_DIGIT, 4'd0);
		send_key(KEY_EQUALS, 4'd0);
		send_key(KEY_ADD, 4'd0);
		send_key(KEY_PERCENT, 4'd0);
		send_key(4'd15, 4'd15);
		send_key(KEY_CLEAR_ENTRY, 4'd0);
		send_key(KEY_DIGIT, 4'd7);
		send_key(KEY_DIV, 4'd0);
		send_key(KEY_DIGIT, 4'd0);
		send_key(KEY_DIV, 4'd0);
		send_key(KEY_DIGIT, 4'd5);
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		int start;
		int pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = keys_sent;
		while (keys_sent - start < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_number();
				send_key(4'($urandom_range(4, 1)), 4'($urandom_range(15)));
			end else if (pick < 70) begin
				send_number();
				send_key(KEY_EQUALS, 4'($urandom_range(15)));
			end else if (pick < 75) begin
				send_key(KEY_NEGATE, 4'($urandom_range(15)));
			end else if (pick < 80) begin
				send_key(KEY_PERCENT, 4'($urandom_range(15)));
			end else if (pick < 84) begin
				send_key(KEY_CLEAR_ENTRY, 4'($urandom_range(15)));
			end else if (pick < 87) begin
				send_key(KEY_CLEAR_ALL, 4'($urandom_range(15)));
			end else if (pick < 92) begin
				if ($urandom_range(1) == 0)
					send_key(4'($urandom_range(15, 10)), 4'($urandom_range(15)));
				else
					send_key(KEY_DIGIT, 4'($urandom_range(15, 10)));
			end else begin
				send_key(4'($urandom_range(15)), 4'($urandom_range(15)));
			end
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_gen++;
		repeat (5) begin
			send_number();
			send_key(KEY_MUL, 4'd0);
			send_key(KEY_DIGIT, 4'($urandom_range(9, 1)));
			send_key(KEY_DIV, 4'd0);
			send_key(KEY_PERCENT, 4'd0);
		end
	endtask

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_gen != hold_seen) begin
				hold_seen = hold_gen;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready = 1'b0;
			end else begin
				res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		display_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (shown_q.size() == 0) begin
				$error("unexpected result transfer: shown_value %0d", res_ch.shown_value);
				fail_count++;
			end else begin
				want = shown_q.pop_front();
				if (res_ch.shown_value !== want.shown) begin
					$error("shown_value: expected %0d, actual %0d", want.shown,
						res_ch.shown_value);
					fail_count++;
				end
				if (res_ch.error_flag !== want.err) begin
					$error("error_flag: expected %0b, actual %0b", want.err,
						res_ch.error_flag);
					fail_count++;
				end
				if (res_ch.pending_op !== want.op) begin
					$error("pending_op: expected %0d, actual %0d", want.op,
						res_ch.pending_op);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		key_ch.valid = 1'b0;
		key_ch.kind = KEY_DIGIT;
		key_ch.digit = 4'd0;
		arst_n = 1'b0;
		calc_clear();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_entry_limit();
		test_overflow_division();
		test_error_recovery();
		test_random_phase(0, 0, 145);
		test_random_phase(48, 0, 145);
		test_random_phase(0, 48, 145);
		test_random_phase(12, 12, 145);
		test_backpressure();
		key_ch.valid = 1'b0;

		while (shown_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && shown_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
